// ===== rtl/core/bhsv_pkg.sv =====
package bhsv_pkg;

  // Default channel width of the blue, green and red samples
  localparam int CHANNEL_BITS_DEF = 8;

  // Quotient bits resolved by the divider chain, one per cell
  localparam int QUOT_BITS = 10;
  // Saturation numerator is delta scaled by 256
  localparam int SAT_SHIFT = 8;

  localparam int HUE_BITS = 13;
  localparam int SAT_BITS = 9;
  localparam int VAL_BITS = 8;

  // Hue in sixteenths of a degree: 60 degrees per sector
  localparam int HUE_SECTOR = 960;
  localparam int HUE_GREEN  = 1920;
  localparam int HUE_BLUE   = 3840;
  localparam int HUE_FULL   = 5760;
  localparam int SAT_ONE    = 256;

  localparam int OUT_BITS    = HUE_BITS + SAT_BITS + VAL_BITS;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Channel that holds the maximum, ties resolved red, green, blue
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // Side information that travels beside the divider data
  typedef struct packed {
    logic                valid;
    sector_t             sector;
    logic                neg;     // hue difference was negative
    logic                grey;    // delta is zero
    logic [VAL_BITS-1:0] bright;
  } ctl_t;

endpackage

// ===== rtl/core/bhsv_front.sv =====
module bhsv_front
  import bhsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [CHANNEL_BITS-1:0] blue,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [VAL_BITS-1:0]     brightness,
  output ctl_t                    ctl,
  output logic [CHANNEL_BITS-1:0] hrem,
  output logic [CHANNEL_BITS-1:0] hden,
  output logic [QUOT_BITS-1:0]    hsh,
  output logic [CHANNEL_BITS-1:0] srem,
  output logic [CHANNEL_BITS-1:0] sden,
  output logic [QUOT_BITS-1:0]    ssh
);

  localparam int NUM_W = CHANNEL_BITS + QUOT_BITS;

  logic [CHANNEL_BITS-1:0] mx, mn, delta, op_a, op_b, mag;
  logic                    neg;
  sector_t                 sector;
  logic [NUM_W-1:0]        hnum, snum;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;

    if (mx == red) begin
      sector = SECT_RED;
      op_a   = green;
      op_b   = blue;
    end else if (mx == green) begin
      sector = SECT_GREEN;
      op_a   = blue;
      op_b   = red;
    end else begin
      sector = SECT_BLUE;
      op_a   = red;
      op_b   = green;
    end

    neg  = op_a < op_b;
    mag  = neg ? (op_b - op_a) : (op_a - op_b);
    hnum = NUM_W'(mag) * NUM_W'(HUE_SECTOR);
    snum = NUM_W'({delta, {SAT_SHIFT{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl.valid  <= in_valid;
      ctl.sector <= sector;
      ctl.neg    <= neg;
      ctl.grey   <= (delta == '0);
      ctl.bright <= brightness;
    end
  end

  // Top part of each numerator is already below its divisor
  always_ff @(posedge clk) begin
    if (en) begin
      hrem <= hnum[NUM_W-1:QUOT_BITS];
      hsh  <= hnum[QUOT_BITS-1:0];
      hden <= delta;
      srem <= snum[NUM_W-1:QUOT_BITS];
      ssh  <= snum[QUOT_BITS-1:0];
      sden <= mx;
    end
  end

endmodule

// ===== rtl/core/bhsv_div_cell.sv =====
module bhsv_div_cell
  import bhsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  ctl_t                    ctl_in,
  input  logic [CHANNEL_BITS-1:0] hrem_in,
  input  logic [CHANNEL_BITS-1:0] hden_in,
  input  logic [QUOT_BITS-1:0]    hsh_in,
  input  logic [CHANNEL_BITS-1:0] srem_in,
  input  logic [CHANNEL_BITS-1:0] sden_in,
  input  logic [QUOT_BITS-1:0]    ssh_in,
  output ctl_t                    ctl_out,
  output logic [CHANNEL_BITS-1:0] hrem_out,
  output logic [CHANNEL_BITS-1:0] hden_out,
  output logic [QUOT_BITS-1:0]    hsh_out,
  output logic [CHANNEL_BITS-1:0] srem_out,
  output logic [CHANNEL_BITS-1:0] sden_out,
  output logic [QUOT_BITS-1:0]    ssh_out
);

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [CHANNEL_BITS:0] div_step(
    input logic [CHANNEL_BITS-1:0] rem,
    input logic                    bit_in,
    input logic [CHANNEL_BITS-1:0] den
  );
    logic [CHANNEL_BITS:0] trial;
    logic [CHANNEL_BITS:0] diff;
    trial = {rem, bit_in};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {1'b1, diff[CHANNEL_BITS-1:0]};
    end
    return {1'b0, trial[CHANNEL_BITS-1:0]};
  endfunction

  logic [CHANNEL_BITS:0] hstep, sstep;

  assign hstep = div_step(hrem_in, hsh_in[QUOT_BITS-1], hden_in);
  assign sstep = div_step(srem_in, ssh_in[QUOT_BITS-1], sden_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  // Shift numerator bits out at the top, quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (en) begin
      hrem_out <= hstep[CHANNEL_BITS-1:0];
      hden_out <= hden_in;
      hsh_out  <= {hsh_in[QUOT_BITS-2:0], hstep[CHANNEL_BITS]};
      srem_out <= sstep[CHANNEL_BITS-1:0];
      sden_out <= sden_in;
      ssh_out  <= {ssh_in[QUOT_BITS-2:0], sstep[CHANNEL_BITS]};
    end
  end

endmodule

// ===== rtl/core/bhsv_out.sv =====
module bhsv_out
  import bhsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_t                    ctl_in,
  input  logic [CHANNEL_BITS-1:0] hrem_in,
  input  logic [QUOT_BITS-1:0]    hq_in,
  input  logic [QUOT_BITS-1:0]    sq_in,
  output logic                    en,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_TDATA_W-1:0]  m_tdata
);

  logic [HUE_BITS-1:0]    base, quot, hue;
  logic [SAT_BITS-1:0]    sat;
  logic [OUT_TDATA_W-1:0] res;
  logic [OUT_TDATA_W-1:0] skid;
  logic                   skid_valid;
  logic                   take_out;

  always_comb begin
    quot = HUE_BITS'(hq_in);
    unique case (ctl_in.sector)
      SECT_RED:   base = ctl_in.neg ? HUE_BITS'(HUE_FULL) : '0;
      SECT_GREEN: base = HUE_BITS'(HUE_GREEN);
      SECT_BLUE:  base = HUE_BITS'(HUE_BLUE);
      default:    base = '0;
    endcase

    // Floor of a negative quotient steps down once more on a remainder
    if (ctl_in.grey) begin
      hue = '0;
    end else if (ctl_in.neg) begin
      hue = base - quot - HUE_BITS'(hrem_in != '0);
    end else begin
      hue = base + quot;
    end

    sat = ctl_in.grey ? '0 : SAT_BITS'(sq_in);
    res = OUT_TDATA_W'({ctl_in.bright, sat, hue});
  end

  assign en       = !skid_valid;
  assign take_out = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (take_out) begin
      m_tvalid <= ctl_in.valid;
    end else if (ctl_in.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        m_tdata <= skid;
      end
    end else if (take_out) begin
      m_tdata <= res;
    end else begin
      skid <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid word held without an output word");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[HUE_BITS-1:0] < HUE_BITS'(HUE_FULL))
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[HUE_BITS+SAT_BITS-1:HUE_BITS] <= SAT_BITS'(SAT_ONE))
    else $error("saturation out of range");

  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[HUE_BITS+SAT_BITS-1:HUE_BITS] == '0)
      |-> m_tdata[HUE_BITS-1:0] == '0)
    else $error("grey word carries a hue");

endmodule

// ===== rtl/core/bgr_to_hsv_pixel.sv =====
// An input word is loaded into the front stage at the accepting edge, then
// passes through 10 divider cells and 1 output register to m_tvalid.
// Throughput: one pixel per cycle while the skid stage is empty; each of the
// 10 chained cells resolves one quotient bit of hue and saturation and hands
// its word on whenever the chain is enabled.
// Reset (rst, synchronous, active high) clears all valid flags; no pixel state.
module bgr_to_hsv_pixel
  import bhsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // tdata from bit 0: blue, green, red, brightness, zero fill to bytes
  input  logic [((3*CHANNEL_BITS+VAL_BITS+7)/8)*8-1:0] s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tdata from bit 0: hue [12:0], saturation [21:13], value [29:22], zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int CB = CHANNEL_BITS;

  logic en;

  // Stage arrays: index 0 is the front register, index i+1 is cell i
  ctl_t          ctl_s  [QUOT_BITS+1];
  logic [CB-1:0] hrem_s [QUOT_BITS+1];
  logic [CB-1:0] hden_s [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] hsh_s [QUOT_BITS+1];
  logic [CB-1:0] srem_s [QUOT_BITS+1];
  logic [CB-1:0] sden_s [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] ssh_s [QUOT_BITS+1];

  // Accept whenever the skid stage is empty; the whole chain advances together
  assign s_tready = en;

  // Max, min, delta, sector and both scaled numerators
  bhsv_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .blue      (s_tdata[CB-1:0]),
    .green     (s_tdata[2*CB-1:CB]),
    .red       (s_tdata[3*CB-1:2*CB]),
    .brightness(s_tdata[3*CB+VAL_BITS-1:3*CB]),
    .ctl       (ctl_s[0]),
    .hrem      (hrem_s[0]),
    .hden      (hden_s[0]),
    .hsh       (hsh_s[0]),
    .srem      (srem_s[0]),
    .sden      (sden_s[0]),
    .ssh       (ssh_s[0])
  );

  // Divider chain: hue and saturation quotients, one bit per cell, MSB first
  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
    bhsv_div_cell #(
      .CHANNEL_BITS(CHANNEL_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl_s[i]),
      .hrem_in (hrem_s[i]),
      .hden_in (hden_s[i]),
      .hsh_in  (hsh_s[i]),
      .srem_in (srem_s[i]),
      .sden_in (sden_s[i]),
      .ssh_in  (ssh_s[i]),
      .ctl_out (ctl_s[i+1]),
      .hrem_out(hrem_s[i+1]),
      .hden_out(hden_s[i+1]),
      .hsh_out (hsh_s[i+1]),
      .srem_out(srem_s[i+1]),
      .sden_out(sden_s[i+1]),
      .ssh_out (ssh_s[i+1])
    );
  end

  // Sector offset, floor correction, output register and skid word
  bhsv_out #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_s[QUOT_BITS]),
    .hrem_in (hrem_s[QUOT_BITS]),
    .hq_in   (hsh_s[QUOT_BITS]),
    .sq_in   (ssh_s[QUOT_BITS]),
    .en      (en),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule
